// File: design/usc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_pkg: shared types and constants for the URL syntax checker
// Byte class word, queue sizing, tracker stage codes and result codes.
// ----------------------------------------------------------------------------
package usc_pkg;

  // Byte class word passed from the classifier to the tracker
  typedef struct packed {
    logic last;
    logic is_dot;
    logic is_break;
    logic is_colon;
    logic is_slash;
    logic is_h;
    logic is_t;
    logic is_p;
    logic is_s;
  } cls_t;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_H     = 8'h68;
  localparam logic [7:0] CHR_T     = 8'h74;
  localparam logic [7:0] CHR_P     = 8'h70;
  localparam logic [7:0] CHR_S     = 8'h73;

  // Position in "http:" / "https:"
  localparam logic [2:0] PFX_START = 3'd0;
  localparam logic [2:0] PFX_H     = 3'd1;
  localparam logic [2:0] PFX_HT    = 3'd2;
  localparam logic [2:0] PFX_HTT   = 3'd3;
  localparam logic [2:0] PFX_HTTP  = 3'd4;
  localparam logic [2:0] PFX_HTTPS = 3'd5;
  localparam logic [2:0] PFX_DEAD  = 3'd7;

  // Progress through "://"
  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_COLON = 2'd1;
  localparam logic [1:0] SEP_SLASH = 2'd2;

  // Domain tracking after "://"
  localparam logic [1:0] DOM_IDLE  = 2'd0;
  localparam logic [1:0] DOM_FRESH = 2'd1;
  localparam logic [1:0] DOM_RUN   = 2'd2;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_SEPARATOR  = 3'd1,
    ERR_PROTOCOL   = 3'd2,
    ERR_ZONE       = 3'd3,
    ERR_DOMAIN     = 3'd4,
    ERR_DOUBLE_DOT = 3'd5,
    ERR_TRAIL_DOT  = 3'd6,
    ERR_EMPTY_SUB  = 3'd7
  } err_t;

endpackage

// File: design/usc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_classify: input stage of the URL syntax checker
// Accepts one byte per cycle while in_full is low and registers its class word for the queue.
// ----------------------------------------------------------------------------
module usc_classify (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [7:0]    in_character,
  input  logic          in_last,
  output logic          q_push,
  input  logic          q_full,
  output usc_pkg::cls_t q_word
);

  logic          vld_r;
  logic          vld_nxt;
  usc_pkg::cls_t word_r;
  usc_pkg::cls_t word_nxt;
  logic          take;

  assign q_push  = vld_r;
  assign q_word  = word_r;
  assign in_full = vld_r & q_full;
  assign take    = in_push & ~in_full;

  always_comb begin
    word_nxt.last     = in_last;
    word_nxt.is_dot   = (in_character == usc_pkg::CHR_DOT);
    word_nxt.is_break = (in_character == usc_pkg::CHR_LF) |
                        (in_character == usc_pkg::CHR_CR);
    word_nxt.is_colon = (in_character == usc_pkg::CHR_COLON);
    word_nxt.is_slash = (in_character == usc_pkg::CHR_SLASH);
    word_nxt.is_h     = (in_character == usc_pkg::CHR_H);
    word_nxt.is_t     = (in_character == usc_pkg::CHR_T);
    word_nxt.is_p     = (in_character == usc_pkg::CHR_P);
    word_nxt.is_s     = (in_character == usc_pkg::CHR_S);
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (vld_r & ~q_full) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= word_nxt;
    end
  end

endmodule

// File: design/usc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_queue: class word queue between classifier and tracker
// Small register queue; lets either side stall without stopping the other.
// ----------------------------------------------------------------------------
module usc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  usc_pkg::cls_t wr_word,
  input  logic          pop,
  output logic          empty,
  output usc_pkg::cls_t rd_word
);

  usc_pkg::cls_t              slot_r [usc_pkg::QDepth];
  logic [usc_pkg::QAw-1:0]    wr_ptr_r;
  logic [usc_pkg::QAw-1:0]    wr_ptr_nxt;
  logic [usc_pkg::QAw-1:0]    rd_ptr_r;
  logic [usc_pkg::QAw-1:0]    rd_ptr_nxt;
  logic [usc_pkg::QAw:0]      cnt_r;
  logic [usc_pkg::QAw:0]      cnt_nxt;
  logic                       do_wr;
  logic                       do_rd;

  assign full    = (cnt_r == (usc_pkg::QAw+1)'(usc_pkg::QDepth));
  assign empty   = (cnt_r == '0);
  assign do_wr   = push & ~full;
  assign do_rd   = pop & ~empty;
  assign rd_word = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr & ~do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd & ~do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule

// File: design/usc_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_tracker: pattern tracker and result stage of the URL syntax checker
// Updates the pattern flags per class word and registers the verdict.
// ----------------------------------------------------------------------------
module usc_tracker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  usc_pkg::cls_t q_word,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic          out_valid_res,
  output logic [2:0]    out_error_code
);

  logic [2:0]     pfx_r, pfx_nxt;
  logic           pfx_ok_r, pfx_ok_nxt;
  logic [1:0]     sep_r, sep_nxt;
  logic           sep_seen_r, sep_seen_nxt;
  logic           dsb_r, dsb_nxt;
  logic           zone_r, zone_nxt;
  logic [1:0]     dom_r, dom_nxt;
  logic           dom_found_r, dom_found_nxt;
  logic           prev_dot_r, prev_dot_nxt;
  logic           dbl_r, dbl_nxt;
  logic           esub_r, esub_nxt;
  logic           res_vld_r, res_vld_nxt;
  logic           res_ok_r;
  usc_pkg::err_t  res_code_r;
  usc_pkg::err_t  code;
  logic           completes;
  logic           finish;

  usc_pkg::cls_t  w;

  assign w              = q_word;
  assign out_empty      = ~res_vld_r;
  assign out_valid_res  = res_ok_r;
  assign out_error_code = res_code_r;

  // Non-final words always drain; a final word waits for a free result slot
  assign q_pop  = ~q_empty & (~w.last | ~res_vld_r | out_pop);
  assign finish = q_pop & w.last;

  always_comb begin
    pfx_nxt       = pfx_r;
    pfx_ok_nxt    = pfx_ok_r;
    sep_nxt       = sep_r;
    sep_seen_nxt  = sep_seen_r;
    dsb_nxt       = dsb_r;
    zone_nxt      = zone_r;
    dom_nxt       = dom_r;
    dom_found_nxt = dom_found_r;
    dbl_nxt       = dbl_r;
    esub_nxt      = esub_r;
    completes     = 1'b0;

    case (pfx_r)
      usc_pkg::PFX_START: pfx_nxt = w.is_h ? usc_pkg::PFX_H    : usc_pkg::PFX_DEAD;
      usc_pkg::PFX_H:     pfx_nxt = w.is_t ? usc_pkg::PFX_HT   : usc_pkg::PFX_DEAD;
      usc_pkg::PFX_HT:    pfx_nxt = w.is_t ? usc_pkg::PFX_HTT  : usc_pkg::PFX_DEAD;
      usc_pkg::PFX_HTT:   pfx_nxt = w.is_p ? usc_pkg::PFX_HTTP : usc_pkg::PFX_DEAD;
      usc_pkg::PFX_HTTP: begin
        if (w.is_colon) begin
          pfx_ok_nxt = 1'b1;
        end
        pfx_nxt = w.is_s ? usc_pkg::PFX_HTTPS : usc_pkg::PFX_DEAD;
      end
      usc_pkg::PFX_HTTPS: begin
        if (w.is_colon) begin
          pfx_ok_nxt = 1'b1;
        end
        pfx_nxt = usc_pkg::PFX_DEAD;
      end
      default: pfx_nxt = usc_pkg::PFX_DEAD;
    endcase

    if (w.is_break) begin
      dsb_nxt  = 1'b0;
      zone_nxt = 1'b0;
      dom_nxt  = usc_pkg::DOM_IDLE;
    end else begin
      if (dsb_r) begin
        zone_nxt = 1'b1;
      end
      if (w.is_dot) begin
        dsb_nxt = 1'b1;
      end
      if ((dom_r == usc_pkg::DOM_FRESH) & w.is_dot) begin
        esub_nxt = 1'b1;
      end
      if ((dom_r == usc_pkg::DOM_RUN) & w.is_dot) begin
        dom_found_nxt = 1'b1;
      end
      if (dom_r == usc_pkg::DOM_FRESH) begin
        dom_nxt = usc_pkg::DOM_RUN;
      end
    end

    if (w.is_colon) begin
      sep_nxt = usc_pkg::SEP_COLON;
    end else if (w.is_slash & (sep_r == usc_pkg::SEP_COLON)) begin
      sep_nxt = usc_pkg::SEP_SLASH;
    end else if (w.is_slash & (sep_r == usc_pkg::SEP_SLASH)) begin
      sep_nxt   = usc_pkg::SEP_NONE;
      completes = 1'b1;
    end else begin
      sep_nxt = usc_pkg::SEP_NONE;
    end

    if (completes) begin
      sep_seen_nxt = 1'b1;
      if (dom_nxt == usc_pkg::DOM_IDLE) begin
        dom_nxt = usc_pkg::DOM_FRESH;
      end
    end

    if (w.is_dot & prev_dot_r) begin
      dbl_nxt = 1'b1;
    end
    prev_dot_nxt = w.is_dot;
  end

  // First failed check wins, judged on the flags after this byte
  always_comb begin
    if (!sep_seen_nxt) begin
      code = usc_pkg::ERR_SEPARATOR;
    end else if (!pfx_ok_nxt) begin
      code = usc_pkg::ERR_PROTOCOL;
    end else if (!zone_nxt) begin
      code = usc_pkg::ERR_ZONE;
    end else if (!dom_found_nxt) begin
      code = usc_pkg::ERR_DOMAIN;
    end else if (dbl_nxt) begin
      code = usc_pkg::ERR_DOUBLE_DOT;
    end else if (w.is_dot) begin
      code = usc_pkg::ERR_TRAIL_DOT;
    end else if (esub_nxt) begin
      code = usc_pkg::ERR_EMPTY_SUB;
    end else begin
      code = usc_pkg::ERR_NONE;
    end
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    if (finish) begin
      res_vld_nxt = 1'b1;
    end else if (out_pop & res_vld_r) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      // Clear all flags at reset and after the last byte of each URL
      pfx_r       <= usc_pkg::PFX_START;
      pfx_ok_r    <= 1'b0;
      sep_r       <= usc_pkg::SEP_NONE;
      sep_seen_r  <= 1'b0;
      dsb_r       <= 1'b0;
      zone_r      <= 1'b0;
      dom_r       <= usc_pkg::DOM_IDLE;
      dom_found_r <= 1'b0;
      prev_dot_r  <= 1'b0;
      dbl_r       <= 1'b0;
      esub_r      <= 1'b0;
    end else if (q_pop) begin
      pfx_r       <= pfx_nxt;
      pfx_ok_r    <= pfx_ok_nxt;
      sep_r       <= sep_nxt;
      sep_seen_r  <= sep_seen_nxt;
      dsb_r       <= dsb_nxt;
      zone_r      <= zone_nxt;
      dom_r       <= dom_nxt;
      dom_found_r <= dom_found_nxt;
      prev_dot_r  <= prev_dot_nxt;
      dbl_r       <= dbl_nxt;
      esub_r      <= esub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res_ok_r   <= (code == usc_pkg::ERR_NONE);
      res_code_r <= code;
    end
  end

endmodule

// File: design/url_syntax_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_syntax_checker: streaming URL syntax checker
// Checks a URL arriving one byte per word and reports valid or the first
// failed check after the last byte.
// ----------------------------------------------------------------------------
//  channel | ports                            | handshake
//  --------+----------------------------------+--------------------------
//  input   | in_character[7:0], in_last       | in_push / in_full
//  result  | out_valid_res, out_error_code[2:0] | out_empty / out_pop
//
// One byte is taken every cycle while in_full is low; the last byte passes
// the classifier register, the queue and the result register to the result.
// The tracker updates its flags once for each byte it pops, which sets the rate.
// Reset (rst_n low, synchronous) empties the queue and clears all flags.
// A stalled result only blocks the next URL's last byte; earlier bytes
// keep flowing through the queue into the tracker.
// ----------------------------------------------------------------------------
module url_syntax_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_character,
  input  logic       in_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_valid_res,
  output logic [2:0] out_error_code
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  usc_pkg::cls_t wr_word;
  usc_pkg::cls_t rd_word;

  usc_classify u_classify (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_character (in_character),
    .in_last      (in_last),
    .q_push       (q_push),
    .q_full       (q_full),
    .q_word       (wr_word)
  );

  usc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_word (wr_word),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_word (rd_word)
  );

  usc_tracker u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_word         (rd_word),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_valid_res  (out_valid_res),
    .out_error_code (out_error_code)
  );

endmodule
